// ===== src/plid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plid_pkg : shared codes and types for the positional list
// Command and status codes, datapath operation codes and the structs that
// carry commands and flags between the controller and the datapath.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // datapath operations
  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_INS        = 3'd1;
  localparam logic [2:0] OP_DEL        = 3'd2;
  localparam logic [2:0] OP_DUMP_START = 3'd3;
  localparam logic [2:0] OP_DUMP_STEP  = 3'd4;

  // where an insert or delete lands
  localparam logic [1:0] AT_FRONT = 2'd0;
  localparam logic [1:0] AT_BACK  = 2'd1;
  localparam logic [1:0] AT_POS   = 2'd2;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      at;
    logic            load_out;
    logic [ST_W-1:0] status;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic single;
    logic one_left;
  } dp_flag_t;

endpackage
`default_nettype wire

// ===== src/plid_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plid_ctrl : command sequencer
// Decodes each accepted command into a datapath operation and paces a dump
// one element per cycle against the output handshake.
// ----------------------------------------------------------------------------
module plid_ctrl (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [plid_pkg::CMD_W-1:0]      command,
  output logic                            out_valid,
  input  wire                             out_stall,
  input  plid_pkg::dp_flag_t              flags,
  output plid_pkg::dp_cmd_t               cmd
);
  import plid_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state;
  logic state_next;
  logic slot_free;
  logic accept;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state == S_DUMP) || !slot_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          cmd.last     = 1'b1;
          unique case (command) inside
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
              if (flags.full) begin
                cmd.status = ST_FULL;
              end else if (command == CMD_INS_POS && !flags.ins_pos_ok) begin
                cmd.status = ST_BADPOS;
              end else begin
                cmd.op = OP_INS;
                cmd.at = (command == CMD_INS_FRONT) ? AT_FRONT :
                         (command == CMD_INS_BACK)  ? AT_BACK : AT_POS;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
              if (flags.empty) begin
                cmd.status = ST_EMPTY;
              end else if (command == CMD_DEL_POS && !flags.del_pos_ok) begin
                cmd.status = ST_BADPOS;
              end else begin
                cmd.op = OP_DEL;
                cmd.at = (command == CMD_DEL_FRONT) ? AT_FRONT :
                         (command == CMD_DEL_BACK)  ? AT_BACK : AT_POS;
              end
            end
            CMD_DUMP: begin
              if (flags.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.op   = OP_DUMP_START;
                cmd.last = flags.single;
                if (!flags.single) begin
                  state_next = S_DUMP;
                end
              end
            end
            default: cmd.status = ST_BADPOS;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.op       = OP_DUMP_STEP;
          cmd.load_out = 1'b1;
          cmd.last     = flags.one_left;
          if (flags.one_left) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/plid_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plid_datapath : chain of element cells, count and output word register
// Cells from the landing index on shift at once on insert or delete; a dump
// rotates the live cells; the front one is read each unstalled cycle.
// ----------------------------------------------------------------------------
module plid_datapath #(
  parameter int CAPACITY = plid_pkg::DEF_CAPACITY
) (
  input  wire                                clk,
  input  wire                                rst,
  input  plid_pkg::dp_cmd_t                  cmd,
  output plid_pkg::dp_flag_t                 flags,
  input  wire  signed [plid_pkg::VAL_W-1:0]  value,
  input  wire  [plid_pkg::POS_W-1:0]         position,
  output logic [plid_pkg::ST_W-1:0]          status,
  output logic signed [plid_pkg::VAL_W-1:0]  element,
  output logic [plid_pkg::LEN_W-1:0]         length,
  output logic                               last_of_run
);
  import plid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] remaining;
  logic [CW-1:0] count_m1;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] count_w;
  logic [PW-1:0] pos_m1;
  logic [IW-1:0] idx;
  logic [CW+LEN_W-1:0] len_wide;

  assign count_m1 = count - CW'(1);
  assign pos_w    = PW'(position);
  assign count_w  = PW'(count);
  assign pos_m1   = pos_w - PW'(1);

  assign flags.full       = (count == CW'(CAPACITY));
  assign flags.empty      = (count == '0);
  assign flags.ins_pos_ok = (pos_w != '0) && (pos_w <= count_w + PW'(1));
  assign flags.del_pos_ok = (pos_w != '0) && (pos_w <= count_w);
  assign flags.single     = (count == CW'(1));
  assign flags.one_left   = (remaining == CW'(1));

  // landing index of the insert or delete; only used when in range
  always_comb begin
    case (cmd.at)
      AT_FRONT: idx = '0;
      AT_BACK:  idx = (cmd.op == OP_INS) ? IW'(count) : IW'(count_m1);
      default:  idx = IW'(pos_m1);
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_INS:  count_next = count + CW'(1);
      OP_DEL:  count_next = count_m1;
      default: count_next = count;
    endcase
  end

  assign len_wide = {{LEN_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
    end else begin
      count <= count_next;
      if (cmd.op == OP_DUMP_START) begin
        remaining <= count_m1;
      end else if (cmd.op == OP_DUMP_STEP) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_INS: begin
        if (idx == '0) begin
          cells[0] <= value;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (IW'(i) > idx) begin
            cells[i] <= cells[i-1];
          end else if (IW'(i) == idx) begin
            cells[i] <= value;
          end
        end
      end
      OP_DEL: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IW'(i) >= idx) begin
            cells[i] <= cells[i+1];
          end
        end
      end
      OP_DUMP_START, OP_DUMP_STEP: begin
        // rotate the live cells: front wraps round to the back
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == count_m1) begin
            cells[i] <= cells[0];
          end else if (i < CAPACITY - 1) begin
            cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= cmd.status;
      last_of_run <= cmd.last;
      length      <= len_wide[LEN_W-1:0];
      if (cmd.op == OP_DUMP_START || cmd.op == OP_DUMP_STEP) begin
        element <= cells[0];
      end else begin
        element <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/positional_list_insert_delete.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete : bounded ordered list with positional edits
// Holds up to CAPACITY signed 32-bit values, edited at the front, the back or
// a 1-based position, and dumped front to back.
// ----------------------------------------------------------------------------
// Every command except a dump yields one word, as the cell chain shifts the
// cells from the landing index on at once. A dump of N elements yields N words
// at one per unstalled cycle (the front cell is read while the chain rotates),
// and the next command is taken once the last word has been loaded into the
// output register. A new command is taken while the previous word still waits,
// as long as that word is taken in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int CAPACITY = plid_pkg::DEF_CAPACITY
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [plid_pkg::CMD_W-1:0]         command,
  input  wire  signed [plid_pkg::VAL_W-1:0]  value,
  input  wire  [plid_pkg::POS_W-1:0]         position,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [plid_pkg::ST_W-1:0]          status,
  output logic signed [plid_pkg::VAL_W-1:0]  element,
  output logic [plid_pkg::LEN_W-1:0]         length,
  output logic                               last_of_run
);
  import plid_pkg::*;

  dp_cmd_t  cmd;
  dp_flag_t flags;

  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  plid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flags       (flags),
    .value       (value),
    .position    (position),
    .status      (status),
    .element     (element),
    .length      (length),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

// ===== test/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb : self-checking bench for the positional list
// Feeds list commands through the valid/stall input channel, predicts each
// result word from its own copy of the list and checks every word taken
// from the output channel against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;
  import plid_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    int                      phase;
    bit                      drain;
    bit                      hold;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] command = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [ST_W-1:0] status;
  logic signed [VAL_W-1:0] element;
  logic [LEN_W-1:0] length;
  logic last_of_run;

  list_cmd_t command_queue[$];
  list_word_t expected_words[$];
  logic signed [VAL_W-1:0] list_contents[$];
  int gen_len = 0;
  int mode = 0;
  int failures = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  positional_list_insert_delete #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .element(element),
    .length(length),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int sender_idle_pct(int ph);
    return (ph == 0) ? 8 : (ph == 1) ? 61 : 0;
  endfunction

  function automatic int receiver_idle_pct(int ph);
    return (ph == 0) ? 61 : (ph == 1) ? 8 : 0;
  endfunction

  // Work out the words one command yields and update the list copy.
  function automatic void predict_list_words(logic [CMD_W-1:0] cmd,
                                             logic signed [VAL_W-1:0] val,
                                             logic [POS_W-1:0] pos);
    list_word_t w;
    int n;
    int p;
    n = list_contents.size();
    p = int'(pos);
    w.status = ST_OK;
    w.element = '0;
    w.length = '0;
    w.last = 1'b1;
    case (cmd) inside
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (n >= CAPACITY) w.status = ST_FULL;
        else if (cmd == CMD_INS_FRONT) list_contents.push_front(val);
        else if (cmd == CMD_INS_BACK) list_contents.push_back(val);
        else if (p < 1 || p > n + 1) w.status = ST_BADPOS;
        else list_contents.insert(p - 1, val);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (n == 0) w.status = ST_EMPTY;
        else if (cmd == CMD_DEL_FRONT) void'(list_contents.pop_front());
        else if (cmd == CMD_DEL_BACK) void'(list_contents.pop_back());
        else if (p < 1 || p > n) w.status = ST_BADPOS;
        else list_contents.delete(p - 1);
      end
      CMD_DUMP: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
          expected_words.push_back(w);
        end else begin
          for (int i = 0; i < n; i++) begin
            w.element = list_contents[i];
            w.length = LEN_W'(n);
            w.last = (i == n - 1);
            expected_words.push_back(w);
          end
        end
        return;
      end
      default: w.status = ST_BADPOS;
    endcase
    w.length = LEN_W'(list_contents.size());
    expected_words.push_back(w);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failures++;
    end
  endtask

  // Queue a command and track the length it leaves, to steer positions.
  task automatic add_item(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                          logic [POS_W-1:0] pos, int phase);
    list_cmd_t c;
    int p;
    p = int'(pos);
    c.cmd = cmd;
    c.val = val;
    c.pos = pos;
    c.phase = phase;
    c.drain = 1'b0;
    c.hold = 1'b0;
    command_queue.push_back(c);
    if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK || cmd == CMD_INS_POS) begin
      if (gen_len < CAPACITY && (cmd != CMD_INS_POS || (p >= 1 && p <= gen_len + 1)))
        gen_len++;
    end else if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_BACK || cmd == CMD_DEL_POS) begin
      if (gen_len > 0 && (cmd != CMD_DEL_POS || (p >= 1 && p <= gen_len)))
        gen_len--;
    end
  endtask

  task automatic add_drain();
    list_cmd_t c;
    c.cmd = '0;
    c.val = '0;
    c.pos = '0;
    c.phase = 2;
    c.drain = 1'b1;
    c.hold = 1'b0;
    command_queue.push_back(c);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_burst(int phase, int count);
    int bias;
    int ins_share;
    int roll;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    bias = 2;
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) bias = $urandom_range(2);
      ins_share = (bias == 0) ? 73 : (bias == 1) ? 38 : 57;
      roll = $urandom_range(99);
      if (roll < 10) cmd = CMD_DUMP;
      else if (roll < 13) cmd = CMD_UNUSED;
      else if (roll < ins_share) cmd = CMD_INS_FRONT + CMD_W'($urandom_range(2));
      else cmd = CMD_DEL_FRONT + CMD_W'($urandom_range(2));
      // mostly in range, now and then any position at all
      if ($urandom_range(9) < 8) begin
        if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_BACK || cmd == CMD_DEL_POS)
          pos = (gen_len > 0) ? POS_W'($urandom_range(gen_len, 1)) : '0;
        else
          pos = POS_W'($urandom_range(gen_len + 1, 1));
      end else begin
        pos = POS_W'($urandom_range(31));
      end
      add_item(cmd, rand_value(), pos, phase);
    end
  endtask

  // Driver: advance to the next queued command once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      hold_req <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_list_words(command, value, position);
      if (!in_valid || !in_stall) begin
        if (command_queue.size() != 0 && command_queue[0].drain) begin
          in_valid <= 1'b0;
          hold_req <= 1'b0;
          if (expected_words.size() == 0) void'(command_queue.pop_front());
        end else if (command_queue.size() != 0 &&
                     $urandom_range(99) >= sender_idle_pct(command_queue[0].phase)) begin
          in_valid <= 1'b1;
          command <= command_queue[0].cmd;
          value <= command_queue[0].val;
          position <= command_queue[0].pos;
          mode <= command_queue[0].phase;
          hold_req <= command_queue[0].hold;
          void'(command_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
          hold_req <= 1'b0;
        end
      end else begin
        hold_req <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering commands.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: check every word taken against the oldest prediction.
  always @(posedge clk) begin
    list_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got status %h element %h length %h last %b",
                   $time, status, element, length, last_of_run);
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("element", want.element, element);
          check_field("length", 32'(want.length), 32'(length));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
        end
      end
      out_stall <= (hold_left > 1) || ($urandom_range(99) < receiver_idle_pct(mode));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // empty list corners
    add_item(CMD_DUMP, 0, 0, 0);
    add_item(CMD_DEL_FRONT, 0, 0, 0);
    add_item(CMD_DEL_BACK, 0, 3, 0);
    add_item(CMD_DEL_POS, 0, 1, 0);
    add_item(CMD_INS_POS, 32'sd5, 2, 0);
    add_item(CMD_INS_POS, 32'sd6, 0, 0);
    add_item(CMD_INS_POS, 32'sd0, 1, 0);
    add_item(CMD_INS_FRONT, 32'sh7fffffff, 31, 0);
    add_item(CMD_INS_BACK, 32'sh80000000, 0, 0);
    add_item(CMD_INS_POS, -32'sd1, 4, 0);
    add_item(CMD_INS_POS, 32'sd9, 5, 0);
    add_item(CMD_DEL_POS, 0, 0, 0);
    add_item(CMD_DEL_POS, 0, 5, 0);
    add_item(CMD_DUMP, 0, 0, 0);
    add_item(CMD_UNUSED, -32'sd1, 31, 0);
    add_item(CMD_DEL_POS, 0, 2, 0);
    add_item(CMD_DEL_FRONT, 0, 0, 0);
    add_item(CMD_DEL_BACK, 0, 0, 0);
    add_item(CMD_DUMP, 0, 0, 0);
    add_item(CMD_DEL_POS, 32'sh55555555, 1, 0);
    add_item(CMD_DUMP, 0, 0, 0);
    random_burst(0, 85);
    add_drain();
    random_burst(1, 85);
    add_drain();
    // fill to the brim while the receiver holds off, then overfill and dump
    add_item(CMD_INS_BACK, rand_value(), 0, 2);
    command_queue[$].hold = 1'b1;
    while (gen_len < CAPACITY)
      add_item(CMD_INS_FRONT + CMD_W'($urandom_range(2)), rand_value(),
               POS_W'($urandom_range(gen_len + 1, 1)), 2);
    add_item(CMD_INS_POS, rand_value(), POS_W'($urandom_range(31)), 2);
    add_item(CMD_INS_FRONT, rand_value(), 0, 2);
    add_item(CMD_DUMP, 0, 0, 2);
    add_drain();
    random_burst(2, 70);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (command_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
